// File: rtl/bcu_pkg.sv
// ----------------------------------------------------------------------------
// bcu_pkg
// shared types and constants for the commutation timing update block
// ----------------------------------------------------------------------------
package bcu_pkg;

  localparam logic [7:0]  DemagStep1    = 8'd130;
  localparam logic [7:0]  DemagStep2    = 8'd160;
  localparam logic [2:0]  TimingMax     = 3'd5;
  localparam logic [2:0]  TimingNeutral = 3'd3;
  localparam logic [15:0] StartupWait   = 16'hfff0;
  localparam logic [15:0] Sat16         = 16'hffff;

  // configuration register indexes
  localparam logic RegTiming    = 1'b0;
  localparam logic RegFastClock = 1'b1;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [31:0] event_time;
    logic        fast_clock;
    logic        startup;
    logic        initial_run;
    logic [2:0]  timing;
  } bcu_item_t;

  // period update result between the two back stages
  typedef struct packed {
    logic [15:0] filt_period;
    logic [2:0]  timing;
    logic        startup;
    logic        fast_clock;
    logic        rpm_high;
    logic        took_fast;
    logic        saturated;
  } bcu_upd_t;

endpackage

// File: rtl/bldc_commutation_timing_update.sv
// ----------------------------------------------------------------------------
// bldc_commutation_timing_update
// sensorless commutation period filter and wait generation
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// cfg       in         cfg_write           cfg_index, cfg_data
// in        in         in_valid / in_stall event_time, demag_level, phase flags
// out       out        out_valid/out_stall waits, filt_period, timing, flags
//
// one request per cycle sustained while out_stall is low; an accepted request
// passes the queue, period filter stage and wait stage before out_valid
// the period filter stage computes the new stored period combinationally from the old one
// synchronous reset clears history, period to 0xffff and config to defaults
// out_stall backs up through the wait stage and the two-entry queue
// ----------------------------------------------------------------------------
module bldc_commutation_timing_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] event_time,
  input  logic [7:0]  demag_level,
  input  logic        in_startup,
  input  logic        in_initial_run,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] commutation_wait,
  output logic [15:0] advance_wait,
  output logic [15:0] scan_wait,
  output logic [15:0] timeout_wait,
  output logic [15:0] filt_period,
  output logic [2:0]  timing_used,
  output logic        is_high_rpm,
  output logic        used_fast_path,
  output logic        period_saturated,
  output logic        wait_clamped
);
  import bcu_pkg::*;

  logic      q_full;
  logic      q_push;
  bcu_item_t q_item;
  logic      q_pop;
  logic      q_head_valid;
  bcu_item_t q_head;

  bcu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .event_time     (event_time),
    .demag_level    (demag_level),
    .in_startup     (in_startup),
    .in_initial_run (in_initial_run),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  bcu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .item_in    (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bcu_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (q_head_valid),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .commutation_wait (commutation_wait),
    .advance_wait     (advance_wait),
    .scan_wait        (scan_wait),
    .timeout_wait     (timeout_wait),
    .filt_period      (filt_period),
    .timing_used      (timing_used),
    .is_high_rpm      (is_high_rpm),
    .used_fast_path   (used_fast_path),
    .period_saturated (period_saturated),
    .wait_clamped     (wait_clamped)
  );

`ifndef ASSERT_OFF
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  a_push_to_head: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_head_valid |=> q_head_valid)
    else $error("pushed request not visible at queue head");

  a_timing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> timing_used <= TimingMax && advance_wait != 16'd0)
    else $error("timing level or advance wait out of range");

  a_clamp_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_clamped |->
      (commutation_wait == 16'd1 || advance_wait == 16'd1 || scan_wait == 16'd1))
    else $error("wait clamp flag without a clamped wait");

  a_high_rpm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_high_rpm == (filt_period[15:9] == 7'd0))
    else $error("high rpm flag disagrees with filtered period");
`endif

endmodule

// File: rtl/bcu_front.sv
// ----------------------------------------------------------------------------
// bcu_front
// configuration registers, request intake and timing level classification
// ----------------------------------------------------------------------------
module bcu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [2:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       event_time,
  input  logic [7:0]        demag_level,
  input  logic              in_startup,
  input  logic              in_initial_run,
  input  logic              q_full,
  output logic              q_push,
  output bcu_pkg::bcu_item_t q_item
);
  import bcu_pkg::*;

  logic [2:0] programmed_timing;
  logic       fast_clock;
  logic [3:0] timing_sum;
  logic [2:0] timing_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      programmed_timing <= TimingNeutral;
      fast_clock        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegTiming:    programmed_timing <= cfg_data;
        RegFastClock: fast_clock        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // demag raises the advance by up to two steps
  always_comb begin
    timing_sum = {1'b0, programmed_timing}
               + {3'b000, (demag_level >= DemagStep1)}
               + {3'b000, (demag_level >= DemagStep2)};
    if (in_startup) begin
      timing_eff = TimingNeutral;
    end else if (timing_sum > {1'b0, TimingMax}) begin
      timing_eff = TimingMax;
    end else begin
      timing_eff = timing_sum[2:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.event_time  = event_time;
    q_item.fast_clock  = fast_clock;
    q_item.startup     = in_startup;
    q_item.initial_run = in_initial_run;
    q_item.timing      = timing_eff;
  end

endmodule

// File: rtl/bcu_queue.sv
// ----------------------------------------------------------------------------
// bcu_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module bcu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bcu_pkg::bcu_item_t item_in,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output bcu_pkg::bcu_item_t head
);
  import bcu_pkg::*;

  bcu_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

endmodule

// File: rtl/bcu_back.sv
// ----------------------------------------------------------------------------
// bcu_back
// period filter with timestamp history, then wait computation and output
// ----------------------------------------------------------------------------
module bcu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  bcu_pkg::bcu_item_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        commutation_wait,
  output logic [15:0]        advance_wait,
  output logic [15:0]        scan_wait,
  output logic [15:0]        timeout_wait,
  output logic [15:0]        filt_period,
  output logic [2:0]         timing_used,
  output logic               is_high_rpm,
  output logic               used_fast_path,
  output logic               period_saturated,
  output logic               wait_clamped
);
  import bcu_pkg::*;

  logic [31:0] last_time;
  logic [31:0] second_last_time;
  logic [15:0] period_estimate;
  logic        high_rpm_flag;

  logic        a_valid;
  bcu_upd_t    a_reg;
  bcu_upd_t    a_next;
  logic        a_take;
  logic        b_load;

  logic [31:0] cur;
  logic [31:0] prev;
  logic [31:0] prev2;
  logic [15:0] delta;
  logic [15:0] old_shr;
  logic [15:0] delta_shr;
  logic [16:0] np;
  logic        fast;
  logic        delta_sat;

  logic [15:0] period;
  logic [14:0] quarter;
  logic [16:0] adv;
  logic [15:0] adv_w;
  logic [14:0] scan_q;

  assign b_load = a_valid && (!out_valid || !out_stall);
  assign a_take = head_valid && (!a_valid || b_load);
  assign pop    = a_take;

  // period update
  always_comb begin
    cur       = head.fast_clock ? {1'b0, head.event_time[31:1]} : head.event_time;
    prev      = head.fast_clock ? {1'b0, last_time[31:1]} : last_time;
    prev2     = head.fast_clock ? {1'b0, second_last_time[31:1]} : second_last_time;
    fast      = high_rpm_flag || (period_estimate[15:9] == 7'd0);
    delta_sat = 1'b0;
    delta     = 16'd0;
    old_shr   = 16'd0;
    delta_shr = 16'd0;
    np        = 17'd0;
    if (head.startup) begin
      if (cur[31:16] != prev[31:16]) begin
        delta     = Sat16;
        delta_sat = 1'b1;
      end else begin
        delta = cur[15:0] - prev2[15:0];
      end
      np = {2'b00, period_estimate[15:1]} + {1'b0, delta};
    end else begin
      delta = cur[15:0] - prev[15:0];
      if (fast) begin
        old_shr   = period_estimate >> 4;
        delta_shr = delta >> 2;
      end else if (period_estimate[15:11] != 5'd0 && !head.initial_run) begin
        old_shr   = period_estimate >> 2;
        delta_shr = delta;
      end else if (period_estimate[15:10] != 6'd0) begin
        old_shr   = period_estimate >> 3;
        delta_shr = delta >> 1;
      end else begin
        old_shr   = period_estimate >> 4;
        delta_shr = delta >> 2;
      end
      np = {1'b0, period_estimate - old_shr} + {1'b0, delta_shr};
    end
    a_next.filt_period = np[16] ? Sat16 : np[15:0];
    a_next.saturated   = np[16] || delta_sat;
    a_next.rpm_high    = np[16] ? 1'b0 : (np[15:9] == 7'd0);
    a_next.timing      = head.timing;
    a_next.startup     = head.startup;
    a_next.fast_clock  = head.fast_clock;
    a_next.took_fast   = fast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time        <= 32'd0;
      second_last_time <= 32'd0;
      period_estimate  <= Sat16;
      high_rpm_flag    <= 1'b0;
      a_valid          <= 1'b0;
    end else begin
      if (a_take) begin
        second_last_time <= last_time;
        last_time        <= head.event_time;
        period_estimate  <= a_next.filt_period;
        high_rpm_flag    <= a_next.rpm_high;
      end
      if (a_take) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_reg <= a_next;
    end
  end

  // wait computation
  always_comb begin
    period  = a_reg.fast_clock ? {1'b0, a_reg.filt_period[15:1]} : a_reg.filt_period;
    quarter = (period[15:1] == 15'd0) ? 15'd1 : period[15:1];
    if (a_reg.timing > TimingNeutral) begin
      if (!a_reg.timing[0]) begin
        adv = {2'b00, quarter} + {3'b000, quarter[14:1]};
      end else begin
        adv = {2'b00, quarter} + {2'b00, quarter};
      end
    end else if (a_reg.timing < TimingNeutral) begin
      adv = {2'b00, quarter} - {3'b000, quarter[14:1]};
    end else begin
      adv = {2'b00, quarter};
    end
    adv_w  = (adv[15:0] == 16'd0) ? 16'd1 : adv[15:0];
    scan_q = (quarter[14:1] == 14'd0) ? 15'd1 : {1'b0, quarter[14:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      commutation_wait <= a_reg.startup ? StartupWait : {1'b0, quarter};
      advance_wait     <= adv_w;
      scan_wait        <= a_reg.startup ? StartupWait : {1'b0, scan_q};
      timeout_wait     <= a_reg.startup ? StartupWait : {1'b0, quarter};
      filt_period      <= a_reg.filt_period;
      timing_used      <= a_reg.timing;
      is_high_rpm      <= a_reg.rpm_high;
      used_fast_path   <= a_reg.took_fast;
      period_saturated <= a_reg.saturated;
      wait_clamped     <= !a_reg.startup
                          && (quarter == 15'd1 || adv_w == 16'd1 || scan_q == 15'd1);
    end
  end

endmodule
